/* rtl/core/kme_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// Shared widths, field codes and register indexes of the keypad mouse emulator.
// No dependencies; the RTL files use these by scoped name, the bench imports them.
package kme_pkg;

   localparam int TICK_BITS  = 16;
   localparam int DIGIT_BITS = 4;
   localparam int MAC_STEPS  = (TICK_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
   localparam int STEP_W     = $clog2(MAC_STEPS);
   localparam int NSH_W      = MAC_STEPS * DIGIT_BITS;
   localparam int COEF_W     = 48;
   localparam int ACC_W      = COEF_W + 2 * TICK_BITS + 2;
   localparam int FRAC_SHIFT = 16;
   localparam int SPEED_W    = 32;
   localparam int SAT_LSB    = FRAC_SHIFT + SPEED_W - 1;
   localparam int LIMIT_W    = 31;
   localparam int CSR_IDX_W  = 3;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 72;

   localparam logic [SPEED_W-1:0] SPEED_MAX = {1'b0, {(SPEED_W-1){1'b1}}};
   localparam logic [SPEED_W-1:0] SPEED_MIN = {1'b1, {(SPEED_W-1){1'b0}}};

   localparam logic [CSR_IDX_W-1:0] CSR_QUAD  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIN   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CONST = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_Y = 3'd4;

   localparam logic MODE_TICK = 1'b1;

   localparam logic [3:0] ACT_UP         = 4'd3;
   localparam logic [3:0] ACT_CLICK      = 4'd4;
   localparam logic [3:0] ACT_DOUBLE     = 4'd5;
   localparam logic [3:0] ACT_DRAG_START = 4'd6;
   localparam logic [3:0] ACT_DRAG_END   = 4'd7;
   localparam logic [3:0] ACT_PRIMARY    = 4'd8;
   localparam logic [3:0] ACT_TERTIARY   = 4'd9;
   localparam logic [3:0] ACT_SECONDARY  = 4'd10;

   localparam logic [1:0] EV_UP     = 2'd0;
   localparam logic [1:0] EV_DOWN   = 2'd1;
   localparam logic [1:0] EV_REPEAT = 2'd2;

   localparam logic [1:0] KIND_STATUS  = 2'd0;
   localparam logic [1:0] KIND_MOTION  = 2'd1;
   localparam logic [1:0] KIND_PRESS   = 2'd2;
   localparam logic [1:0] KIND_RELEASE = 2'd3;

   localparam logic [2:0] BTN_PRIMARY   = 3'd1;
   localparam logic [2:0] BTN_SECONDARY = 3'd2;
   localparam logic [2:0] BTN_TERTIARY  = 3'd4;

endpackage
`default_nettype wire

/* rtl/core/kme_speed_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Digit-serial speed unit: evaluates (Q*n + L)*n + C in two shift-add passes
// over the tick count, then floors to Q16.16 and saturates. Uses kme_pkg.
module kme_speed_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [kme_pkg::TICK_BITS-1:0]     ticks,
   input  logic [kme_pkg::COEF_W-1:0]        quad_coef,
   input  logic [kme_pkg::COEF_W-1:0]        lin_coef,
   input  logic [kme_pkg::COEF_W-1:0]        const_coef,
   output logic                              done,
   output logic [kme_pkg::SPEED_W-1:0]       speed
);

   typedef enum logic [1:0] {ST_IDLE, ST_PASS1, ST_PASS2, ST_FINISH} state_type;

   state_type                         state_ff, state_in;
   logic                              done_ff, done_in;
   logic [kme_pkg::STEP_W-1:0]        step_ff, step_in;
   logic [kme_pkg::NSH_W-1:0]         nsh_ff, nsh_in;
   logic [kme_pkg::TICK_BITS-1:0]     ticks_ff, ticks_in;
   logic [kme_pkg::ACC_W-1:0]         acc_ff, acc_in, mcand_ff, mcand_in, acc_sum;
   logic [kme_pkg::SPEED_W-1:0]       speed_ff, speed_in;
   logic [kme_pkg::ACC_W-kme_pkg::SAT_LSB-1:0] top_bits;
   logic                              last_step, fits;

   assign acc_sum   = acc_ff + mcand_ff
                      * kme_pkg::ACC_W'(nsh_ff[kme_pkg::DIGIT_BITS-1:0]);
   assign last_step = (step_ff == kme_pkg::STEP_W'(kme_pkg::MAC_STEPS - 1));
   assign top_bits  = acc_ff[kme_pkg::ACC_W-1:kme_pkg::SAT_LSB];
   assign fits      = (&top_bits) || !(|top_bits);

   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      nsh_in   = nsh_ff;
      ticks_in = ticks_ff;
      acc_in   = acc_ff;
      mcand_in = mcand_ff;
      speed_in = speed_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ticks_in = ticks;
               nsh_in   = kme_pkg::NSH_W'(ticks);
               acc_in   = kme_pkg::ACC_W'($signed(lin_coef));
               mcand_in = kme_pkg::ACC_W'($signed(quad_coef));
               step_in  = '0;
               state_in = ST_PASS1;
            end
         end
         ST_PASS1: begin
            acc_in   = acc_sum;
            mcand_in = mcand_ff << kme_pkg::DIGIT_BITS;
            nsh_in   = nsh_ff >> kme_pkg::DIGIT_BITS;
            step_in  = step_ff + kme_pkg::STEP_W'(1);
            if (last_step) begin
               mcand_in = acc_sum;
               acc_in   = kme_pkg::ACC_W'($signed(const_coef));
               nsh_in   = kme_pkg::NSH_W'(ticks_ff);
               step_in  = '0;
               state_in = ST_PASS2;
            end
         end
         ST_PASS2: begin
            acc_in   = acc_sum;
            mcand_in = mcand_ff << kme_pkg::DIGIT_BITS;
            nsh_in   = nsh_ff >> kme_pkg::DIGIT_BITS;
            step_in  = step_ff + kme_pkg::STEP_W'(1);
            if (last_step) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (fits) begin
               speed_in = acc_ff[kme_pkg::SAT_LSB:kme_pkg::FRAC_SHIFT];
            end else if (acc_ff[kme_pkg::ACC_W-1]) begin
               speed_in = kme_pkg::SPEED_MIN;
            end else begin
               speed_in = kme_pkg::SPEED_MAX;
            end
            done_in  = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      nsh_ff   <= nsh_in;
      ticks_ff <= ticks_in;
      acc_ff   <= acc_in;
      mcand_ff <= mcand_in;
      speed_ff <= speed_in;
   end

   assign done  = done_ff;
   assign speed = speed_ff;

endmodule
`default_nettype wire

/* rtl/core/kme_axis_clamp.sv */
`timescale 1ns / 1ps
`default_nettype none
// One pointer axis: cancels opposite directions, applies the sign, clamps to
// the axis limit or to the signed 32-bit range. Uses kme_pkg.
module kme_axis_clamp (
   input  logic [kme_pkg::SPEED_W-1:0] speed,
   input  logic                        dir_neg,
   input  logic                        dir_pos,
   input  logic [kme_pkg::LIMIT_W-1:0] limit,
   output logic [kme_pkg::SPEED_W-1:0] disp
);

   logic                        moving, neg_out;
   logic [kme_pkg::SPEED_W-1:0] mag_abs, mag, limit_ext;

   assign moving    = dir_neg ^ dir_pos;
   assign mag_abs   = speed[kme_pkg::SPEED_W-1] ? (~speed + kme_pkg::SPEED_W'(1)) : speed;
   assign limit_ext = kme_pkg::SPEED_W'(limit);
   assign neg_out   = moving && (dir_pos ? speed[kme_pkg::SPEED_W-1]
                                         : (!speed[kme_pkg::SPEED_W-1] && (speed != '0)));

   always_comb begin
      mag = moving ? mag_abs : '0;
      if (limit != '0) begin
         if (mag > limit_ext) mag = limit_ext;
      end else if (!neg_out && (mag > kme_pkg::SPEED_MAX)) begin
         mag = kme_pkg::SPEED_MAX;
      end
   end

   assign disp = neg_out ? (~mag + kme_pkg::SPEED_W'(1)) : mag;

endmodule
`default_nettype wire

/* rtl/core/keypad_mouse_emulator_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Tick with motion active: kme_speed_unit runs its two digit-serial passes, the clamped
//   dx/dy are registered, and S_MOVE loads them once the output register is free.
// Key event: after the accept, S_EMIT loads one result a cycle while the output is free;
//   next word taken once the last result sits in the output register.
// Synchronous active-high reset clears the control state, the output valid flag and
//   the CSRs, selects the primary button; data registers are not reset; no clearing pass.
module keypad_mouse_emulator_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [kme_pkg::REQ_DATA_W-1:0]    req_tdata,  // action[3:0], key_event[5:4], pad
   input  logic                              req_tuser,  // mode
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [kme_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // consumed, buttons[3:1],
                                                         // dx[35:4], dy[67:36], pad
   output logic [1:0]                        rsp_tuser,  // kind
   output logic                              rsp_tlast,
   input  logic                              csr_we,
   input  logic [kme_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [kme_pkg::COEF_W-1:0]        csr_wdata
);

   typedef enum logic [1:0] {S_IDLE, S_CALC, S_MOVE, S_EMIT} state_type;
   typedef enum logic [1:0] {SEQ_STATUS, SEQ_ALT, SEQ_PRESS, SEQ_RELEASE} seq_type;

   state_type                     state_ff, state_in;
   seq_type                       seq_mode_ff, seq_mode_in;
   logic [2:0]                    seq_left_ff, seq_left_in;
   logic                          seq_phase_ff, seq_phase_in;
   logic                          seq_cons_ff, seq_cons_in;
   logic [3:0]                    held_ff, held_in;
   logic                          motion_ff, motion_in;
   logic [kme_pkg::TICK_BITS-1:0] elapsed_ff, elapsed_in;
   logic [2:0]                    sel_ff, sel_in;
   logic                          drag_ff, drag_in;
   logic [2:0]                    press_btn_ff, press_btn_in, move_btn_ff, move_btn_in;
   logic [kme_pkg::SPEED_W-1:0]   dx_ff, dx_in, dy_ff, dy_in;

   logic [kme_pkg::COEF_W-1:0]    quad_ff, lin_ff, const_ff;
   logic [kme_pkg::LIMIT_W-1:0]   max_x_ff, max_y_ff;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [1:0]                    rsp_kind_ff, rsp_kind_in;
   logic                          rsp_cons_ff, rsp_cons_in;
   logic [2:0]                    rsp_btn_ff, rsp_btn_in;
   logic [kme_pkg::SPEED_W-1:0]   rsp_dx_ff, rsp_dx_in, rsp_dy_ff, rsp_dy_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic                          req_accept, out_free, spd_start, spd_done, seq_last;
   logic [3:0]                    req_action, dir_bit;
   logic [1:0]                    req_event;
   logic [kme_pkg::SPEED_W-1:0]   spd_speed, axis_x, axis_y;

   assign req_action = req_tdata[3:0];
   assign req_event  = req_tdata[5:4];
   assign dir_bit    = 4'b0001 << req_action[1:0];
   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign seq_last   = (seq_left_ff == 3'd1);

   kme_speed_unit u_speed (
      .clock      (clock),
      .reset      (reset),
      .start      (spd_start),
      .ticks      (elapsed_ff),
      .quad_coef  (quad_ff),
      .lin_coef   (lin_ff),
      .const_coef (const_ff),
      .done       (spd_done),
      .speed      (spd_speed)
   );

   kme_axis_clamp u_axis_x (
      .speed   (spd_speed),
      .dir_neg (held_ff[1]),
      .dir_pos (held_ff[2]),
      .limit   (max_x_ff),
      .disp    (axis_x)
   );

   kme_axis_clamp u_axis_y (
      .speed   (spd_speed),
      .dir_neg (held_ff[3]),
      .dir_pos (held_ff[0]),
      .limit   (max_y_ff),
      .disp    (axis_y)
   );

   always_comb begin
      state_in     = state_ff;
      seq_mode_in  = seq_mode_ff;
      seq_left_in  = seq_left_ff;
      seq_phase_in = seq_phase_ff;
      seq_cons_in  = seq_cons_ff;
      held_in      = held_ff;
      motion_in    = motion_ff;
      elapsed_in   = elapsed_ff;
      sel_in       = sel_ff;
      drag_in      = drag_ff;
      press_btn_in = press_btn_ff;
      move_btn_in  = move_btn_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_cons_in  = rsp_cons_ff;
      rsp_btn_in   = rsp_btn_ff;
      rsp_dx_in    = rsp_dx_ff;
      rsp_dy_in    = rsp_dy_ff;
      rsp_last_in  = rsp_last_ff;
      spd_start    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (req_tuser == kme_pkg::MODE_TICK) begin
                  if (motion_ff) begin
                     spd_start   = 1'b1;
                     move_btn_in = drag_ff ? sel_ff : 3'd0;
                     state_in    = S_CALC;
                  end
               end else begin
                  seq_mode_in  = SEQ_STATUS;
                  seq_left_in  = 3'd1;
                  seq_phase_in = 1'b0;
                  seq_cons_in  = 1'b1;
                  press_btn_in = sel_ff;
                  state_in     = S_EMIT;
                  if (req_action <= kme_pkg::ACT_UP) begin
                     case (req_event)
                        kme_pkg::EV_DOWN: begin
                           held_in = held_ff | dir_bit;
                           if (!motion_ff) begin
                              motion_in  = 1'b1;
                              elapsed_in = '0;
                           end
                        end
                        kme_pkg::EV_UP: begin
                           held_in = held_ff & ~dir_bit;
                           if (held_in == 4'd0) motion_in = 1'b0;
                        end
                        kme_pkg::EV_REPEAT: seq_cons_in = 1'b1;
                        default: seq_cons_in = 1'b0;
                     endcase
                  end else if (req_action > kme_pkg::ACT_SECONDARY) begin
                     seq_cons_in = 1'b0;
                  end else if (req_event == kme_pkg::EV_DOWN
                               || req_event == kme_pkg::EV_REPEAT) begin
                     seq_cons_in = 1'b1;
                  end else begin
                     drag_in = 1'b0;
                     case (req_action)
                        kme_pkg::ACT_CLICK: begin
                           seq_mode_in = SEQ_ALT;
                           seq_left_in = 3'd2;
                        end
                        kme_pkg::ACT_DOUBLE: begin
                           seq_mode_in = SEQ_ALT;
                           seq_left_in = 3'd4;
                        end
                        kme_pkg::ACT_DRAG_START: begin
                           seq_mode_in = SEQ_PRESS;
                           drag_in     = 1'b1;
                        end
                        kme_pkg::ACT_DRAG_END: seq_mode_in = SEQ_RELEASE;
                        kme_pkg::ACT_PRIMARY: begin
                           sel_in      = kme_pkg::BTN_PRIMARY;
                           seq_mode_in = SEQ_RELEASE;
                        end
                        kme_pkg::ACT_TERTIARY: begin
                           sel_in      = kme_pkg::BTN_TERTIARY;
                           seq_mode_in = SEQ_RELEASE;
                        end
                        default: begin
                           sel_in      = kme_pkg::BTN_SECONDARY;
                           seq_mode_in = SEQ_RELEASE;
                        end
                     endcase
                  end
               end
            end
         end
         S_CALC: begin
            if (spd_done) begin
               dx_in    = axis_x;
               dy_in    = axis_y;
               state_in = S_MOVE;
            end
         end
         S_MOVE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = kme_pkg::KIND_MOTION;
               rsp_cons_in  = 1'b0;
               rsp_btn_in   = move_btn_ff;
               rsp_dx_in    = dx_ff;
               rsp_dy_in    = dy_ff;
               rsp_last_in  = 1'b1;
               if (dx_ff == '0 && dy_ff == '0) begin
                  elapsed_in = kme_pkg::TICK_BITS'(1);
               end else if (!(&elapsed_ff)) begin
                  elapsed_in = elapsed_ff + kme_pkg::TICK_BITS'(1);
               end
               state_in = S_IDLE;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_cons_in  = seq_cons_ff;
               rsp_dx_in    = '0;
               rsp_dy_in    = '0;
               rsp_last_in  = seq_last;
               case (seq_mode_ff)
                  SEQ_PRESS: begin
                     rsp_kind_in = kme_pkg::KIND_PRESS;
                     rsp_btn_in  = press_btn_ff;
                  end
                  SEQ_RELEASE: begin
                     rsp_kind_in = kme_pkg::KIND_RELEASE;
                     rsp_btn_in  = 3'd0;
                  end
                  SEQ_ALT: begin
                     rsp_kind_in = seq_phase_ff ? kme_pkg::KIND_RELEASE : kme_pkg::KIND_PRESS;
                     rsp_btn_in  = seq_phase_ff ? 3'd0 : press_btn_ff;
                  end
                  default: begin
                     rsp_kind_in = kme_pkg::KIND_STATUS;
                     rsp_btn_in  = 3'd0;
                  end
               endcase
               seq_phase_in = !seq_phase_ff;
               seq_left_in  = seq_left_ff - 3'd1;
               if (seq_last) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         seq_mode_ff  <= SEQ_STATUS;
         seq_left_ff  <= 3'd0;
         seq_phase_ff <= 1'b0;
         seq_cons_ff  <= 1'b0;
         held_ff      <= 4'd0;
         motion_ff    <= 1'b0;
         elapsed_ff   <= '0;
         sel_ff       <= kme_pkg::BTN_PRIMARY;
         drag_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seq_mode_ff  <= seq_mode_in;
         seq_left_ff  <= seq_left_in;
         seq_phase_ff <= seq_phase_in;
         seq_cons_ff  <= seq_cons_in;
         held_ff      <= held_in;
         motion_ff    <= motion_in;
         elapsed_ff   <= elapsed_in;
         sel_ff       <= sel_in;
         drag_ff      <= drag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      press_btn_ff <= press_btn_in;
      move_btn_ff  <= move_btn_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_cons_ff  <= rsp_cons_in;
      rsp_btn_ff   <= rsp_btn_in;
      rsp_dx_ff    <= rsp_dx_in;
      rsp_dy_ff    <= rsp_dy_in;
      rsp_last_ff  <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quad_ff  <= '0;
         lin_ff   <= '0;
         const_ff <= '0;
         max_x_ff <= '0;
         max_y_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            kme_pkg::CSR_QUAD:  quad_ff  <= csr_wdata;
            kme_pkg::CSR_LIN:   lin_ff   <= csr_wdata;
            kme_pkg::CSR_CONST: const_ff <= csr_wdata;
            kme_pkg::CSR_MAX_X: max_x_ff <= csr_wdata[kme_pkg::LIMIT_W-1:0];
            kme_pkg::CSR_MAX_Y: max_y_ff <= csr_wdata[kme_pkg::LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_dy_ff, rsp_dx_ff, rsp_btn_ff, rsp_cons_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_motion_held: assert property (@(posedge clock) disable iff (reset)
      motion_ff == (held_ff != 4'd0))
      else $error("motion flag out of step with held directions");

   a_done_in_calc: assert property (@(posedge clock) disable iff (reset)
      spd_done |-> state_ff == S_CALC)
      else $error("speed result arrived outside calculation");

   a_emit_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EMIT |-> seq_left_ff != 3'd0)
      else $error("emit sequence with no word left");

   a_move_word: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MOVE && out_free) |=> (rsp_tvalid && rsp_tlast && elapsed_ff != '0))
      else $error("motion word not loaded or tick count not advanced");

endmodule
`default_nettype wire

/* sim/keypad_mouse_emulator_unit_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for keypad_mouse_emulator_unit: streams key and tick words,
// predicts the pointer events from its own model of the unit and checks each one.
// Depends on kme_pkg and the unit under test only.
module keypad_mouse_emulator_unit_tb;
   import kme_pkg::*;

   localparam logic [3:0] ACT_DOWN     = 4'd0;
   localparam logic [3:0] ACT_LEFT     = 4'd1;
   localparam logic [3:0] ACT_RIGHT    = 4'd2;
   localparam logic [3:0] ACT_UNMAPPED = 4'd11;
   localparam logic [3:0] ACT_TOP      = 4'd15;
   localparam logic [1:0] EV_NONE      = 2'd3;
   localparam logic       MODE_KEY     = 1'b0;
   localparam logic [2:0] BTN_NONE     = 3'd0;

   localparam int RUN_LIMIT       = 300000;
   localparam int SETTLE_CYCLES   = 32;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int PHASE_WORDS     = 52;
   localparam int RANDOM_PHASES   = 7;

   typedef struct packed {
      logic       mode;
      logic [3:0] action;
      logic [1:0] key_event;
   } keypad_word_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic        consumed;
      logic [2:0]  buttons;
      logic [31:0] dx;
      logic [31:0] dy;
      logic        last;
   } pointer_event_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = CSR_QUAD;
   logic [COEF_W-1:0]     csr_wdata  = '0;

   keypad_mouse_emulator_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // shadow of the unit's registers and state
   logic [COEF_W-1:0]    coef_quad  = '0;
   logic [COEF_W-1:0]    coef_lin   = '0;
   logic [COEF_W-1:0]    coef_const = '0;
   logic [LIMIT_W-1:0]   limit_x    = '0;
   logic [LIMIT_W-1:0]   limit_y    = '0;
   logic [3:0]           dir_mask   = '0;
   logic                 moving     = 1'b0;
   logic [TICK_BITS-1:0] tick_count = '0;
   logic [2:0]           button_sel = BTN_PRIMARY;
   logic                 drag_on    = 1'b0;

   keypad_word_type   pending_words[$];
   pointer_event_type pointer_events_due[$];
   keypad_word_type   offered, next_word;
   int                burst_left, gap_left;
   int                mismatches  = 0;
   int                cycle_count = 0;
   int                hold_off_asks, hold_offs_done, hold_left;
   int                segment_left, stall_style;
   logic [3:0]        gen_mask;
   int                phase_words;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic pointer_event_type make_event(input logic [1:0] kind,
                                                    input logic consumed,
                                                    input logic [2:0] buttons,
                                                    input logic [31:0] dx,
                                                    input logic [31:0] dy);
      pointer_event_type e;
      e.kind     = kind;
      e.consumed = consumed;
      e.buttons  = buttons;
      e.dx       = dx;
      e.dy       = dy;
      e.last     = 1'b0;
      return e;
   endfunction

   function automatic logic [31:0] axis_step(input longint sp, input logic toward_neg,
                                             input logic toward_pos,
                                             input logic [LIMIT_W-1:0] limit);
      longint d, mag, lim;
      d   = 0;
      lim = longint'(limit);
      if (toward_neg && !toward_pos) d = -sp;
      if (toward_pos && !toward_neg) d = sp;
      if (limit != 0) begin
         mag = (d < 0) ? -d : d;
         if (mag > lim) mag = lim;
         d = (d > 0) ? mag : -mag;
      end
      if (d > 64'sd2147483647) d = 64'sd2147483647;
      if (d < -64'sd2147483648) d = -64'sd2147483648;
      return d[31:0];
   endfunction

   task automatic emulate_word(input keypad_word_type w);
      pointer_event_type  out [4];
      logic signed [95:0] q, l, c, n96, total;
      logic signed [31:0] speed;
      logic [31:0]        ex, ey;
      logic               taken;
      int                 k;
      k = 0;
      if (w.mode == MODE_TICK) begin
         if (moving) begin
            q     = 96'($signed(coef_quad));
            l     = 96'($signed(coef_lin));
            c     = 96'($signed(coef_const));
            n96   = 96'(tick_count);
            total = (q * n96 * n96 + l * n96 + c) >>> FRAC_SHIFT;
            if (total > 96'sd2147483647) speed = SPEED_MAX;
            else if (total < -96'sd2147483648) speed = SPEED_MIN;
            else speed = total[31:0];
            ex = axis_step(longint'(speed), dir_mask[ACT_LEFT], dir_mask[ACT_RIGHT], limit_x);
            ey = axis_step(longint'(speed), dir_mask[ACT_UP], dir_mask[ACT_DOWN], limit_y);
            // zero motion restarts acceleration
            if (ex == 0 && ey == 0) tick_count = '0;
            if (tick_count != '1) tick_count = tick_count + 1'b1;
            out[0] = make_event(KIND_MOTION, 1'b0, drag_on ? button_sel : BTN_NONE, ex, ey);
            k = 1;
         end
      end else if (w.action <= ACT_UP) begin
         taken = 1'b1;
         if (w.key_event == EV_DOWN) begin
            dir_mask = dir_mask | (4'd1 << w.action);
            if (!moving) begin
               moving     = 1'b1;
               tick_count = '0;
            end
         end else if (w.key_event == EV_UP) begin
            dir_mask = dir_mask & ~(4'd1 << w.action);
            if (dir_mask == 0) moving = 1'b0;
         end else if (w.key_event == EV_NONE) begin
            taken = 1'b0;
         end
         out[0] = make_event(KIND_STATUS, taken, BTN_NONE, 32'd0, 32'd0);
         k = 1;
      end else if (w.action > ACT_SECONDARY) begin
         out[0] = make_event(KIND_STATUS, 1'b0, BTN_NONE, 32'd0, 32'd0);
         k = 1;
      end else if (w.key_event == EV_DOWN || w.key_event == EV_REPEAT) begin
         out[0] = make_event(KIND_STATUS, 1'b1, BTN_NONE, 32'd0, 32'd0);
         k = 1;
      end else begin
         // button actions fire on release, and on a word with no event
         case (w.action)
            ACT_CLICK, ACT_DOUBLE: begin
               out[0] = make_event(KIND_PRESS, 1'b1, button_sel, 32'd0, 32'd0);
               out[1] = make_event(KIND_RELEASE, 1'b1, BTN_NONE, 32'd0, 32'd0);
               out[2] = out[0];
               out[3] = out[1];
               k = (w.action == ACT_DOUBLE) ? 4 : 2;
               drag_on = 1'b0;
            end
            ACT_DRAG_START: begin
               out[0] = make_event(KIND_PRESS, 1'b1, button_sel, 32'd0, 32'd0);
               k = 1;
               drag_on = 1'b1;
            end
            default: begin
               if (w.action == ACT_PRIMARY) button_sel = BTN_PRIMARY;
               else if (w.action == ACT_TERTIARY) button_sel = BTN_TERTIARY;
               else if (w.action == ACT_SECONDARY) button_sel = BTN_SECONDARY;
               out[0] = make_event(KIND_RELEASE, 1'b1, BTN_NONE, 32'd0, 32'd0);
               k = 1;
               drag_on = 1'b0;
            end
         endcase
      end
      for (int i = 0; i < k; i++) begin
         out[i].last = (i == k - 1);
         pointer_events_due.push_back(out[i]);
      end
   endtask

   // driver: bursts of words with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left <= 0;
         gap_left   <= 0;
      end else begin
         if (req_tvalid && req_tready) emulate_word(offered);
         if (req_tvalid && !req_tready) begin
            // hold the offered word
         end else if (gap_left > 0) begin
            gap_left   <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (pending_words.size() > 0) begin
            next_word  = pending_words.pop_front();
            offered    <= next_word;
            req_tdata  <= {2'b00, next_word.key_event, next_word.action};
            req_tuser  <= next_word.mode;
            req_tvalid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 24);
               gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver stall pattern, with one long hold-off asked for in random phase 3
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready     <= 1'b0;
         hold_offs_done <= 0;
         hold_left      <= 0;
         segment_left   <= 0;
         stall_style    <= 0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_offs_done != hold_off_asks) begin
         hold_offs_done <= hold_offs_done + 1;
         hold_left      <= HOLD_OFF_CYCLES;
         rsp_tready     <= 1'b0;
      end else begin
         if (segment_left == 0) begin
            stall_style  <= $urandom_range(0, 3);
            segment_left <= $urandom_range(8, 64);
         end else begin
            segment_left <= segment_left - 1;
         end
         case (stall_style)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= 1'($urandom_range(0, 1));
            2:       rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= !rsp_tready;
         endcase
      end
   end

   task automatic compare_field(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h got %h", $time, what, want, got);
         mismatches++;
      end
   endtask

   // monitor
   always @(posedge clock) begin
      pointer_event_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind     = rsp_tuser;
         got.consumed = rsp_tdata[0];
         got.buttons  = rsp_tdata[3:1];
         got.dx       = rsp_tdata[35:4];
         got.dy       = rsp_tdata[67:36];
         got.last     = rsp_tlast;
         if (pointer_events_due.size() == 0) begin
            $display("%0t: event expected none got %h", $time, got);
            mismatches++;
         end else begin
            want = pointer_events_due.pop_front();
            compare_field("kind", want.kind, got.kind);
            compare_field("consumed", want.consumed, got.consumed);
            compare_field("buttons", want.buttons, got.buttons);
            compare_field("dx", want.dx, got.dx);
            compare_field("dy", want.dy, got.dy);
            compare_field("last", want.last, got.last);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("keypad_mouse_emulator_unit_tb NOT OK");
         $finish;
      end
   end

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_QUAD:  coef_quad  = val;
         CSR_LIN:   coef_lin   = val;
         CSR_CONST: coef_const = val;
         CSR_MAX_X: limit_x    = val[LIMIT_W-1:0];
         CSR_MAX_Y: limit_y    = val[LIMIT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic [COEF_W-1:0] q, input logic [COEF_W-1:0] l,
                                 input logic [COEF_W-1:0] c, input logic [LIMIT_W-1:0] x,
                                 input logic [LIMIT_W-1:0] y);
      write_register(CSR_QUAD, q);
      write_register(CSR_LIN, l);
      write_register(CSR_CONST, c);
      write_register(CSR_MAX_X, {17'd0, x});
      write_register(CSR_MAX_Y, {17'd0, y});
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic queue_word(input logic mode, input logic [3:0] action,
                             input logic [1:0] key_event);
      keypad_word_type w;
      w.mode      = mode;
      w.action    = action;
      w.key_event = key_event;
      pending_words.push_back(w);
      // ticks with motion stopped are dropped by the unit
      if (mode == MODE_TICK) begin
         if (gen_mask != 0) phase_words++;
      end else begin
         phase_words++;
         if (action <= ACT_UP && key_event == EV_DOWN) gen_mask = gen_mask | (4'd1 << action);
         if (action <= ACT_UP && key_event == EV_UP) gen_mask = gen_mask & ~(4'd1 << action);
      end
   endtask

   task automatic queue_tick();
      queue_word(MODE_TICK, 4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)));
   endtask

   task automatic drain_unit();
      do @(negedge clock);
      while (pending_words.size() != 0 || req_tvalid || pointer_events_due.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic [COEF_W-1:0] rand_coef();
      logic [63:0]              raw;
      logic signed [COEF_W-1:0] r;
      raw = {$urandom, $urandom};
      r   = raw[COEF_W-1:0];
      if ($urandom_range(0, 7) == 0) return '0;
      return r >>> $urandom_range(0, COEF_W - 1);
   endfunction

   function automatic logic [LIMIT_W-1:0] rand_limit();
      logic [31:0] raw;
      raw = $urandom;
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return '1;
         default: return raw[LIMIT_W-1:0] >> $urandom_range(0, LIMIT_W - 1);
      endcase
   endfunction

   initial begin
      int start, taps;
      logic [3:0] d;
      hold_off_asks = 0;
      gen_mask      = '0;
      phase_words   = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      apply_settings(48'd1 << 28, 48'd1 << 32, 48'd3 << 31, '0, 31'd5 << 16);
      @(negedge clock);
      queue_word(MODE_TICK, ACT_CLICK, EV_DOWN);
      queue_word(MODE_KEY, ACT_UNMAPPED, EV_UP);
      queue_word(MODE_KEY, ACT_TOP, EV_NONE);
      queue_word(MODE_KEY, ACT_RIGHT, EV_DOWN);
      queue_word(MODE_TICK, ACT_DOWN, EV_UP);
      queue_word(MODE_TICK, ACT_TOP, EV_NONE);
      queue_word(MODE_KEY, ACT_DOWN, EV_DOWN);
      queue_word(MODE_TICK, ACT_DOWN, EV_UP);
      queue_word(MODE_KEY, ACT_LEFT, EV_DOWN);
      queue_word(MODE_TICK, ACT_DOWN, EV_UP);
      queue_word(MODE_KEY, ACT_UP, EV_REPEAT);
      queue_word(MODE_KEY, ACT_UP, EV_NONE);
      queue_word(MODE_KEY, ACT_DOWN, EV_UP);
      queue_word(MODE_TICK, ACT_DOWN, EV_UP);
      queue_word(MODE_KEY, ACT_DRAG_START, EV_UP);
      queue_word(MODE_TICK, ACT_DOWN, EV_UP);
      queue_word(MODE_KEY, ACT_RIGHT, EV_UP);
      queue_word(MODE_KEY, ACT_LEFT, EV_UP);
      queue_word(MODE_TICK, ACT_DOWN, EV_UP);
      queue_word(MODE_KEY, ACT_DRAG_END, EV_UP);
      queue_word(MODE_KEY, ACT_TERTIARY, EV_UP);
      queue_word(MODE_KEY, ACT_CLICK, EV_UP);
      queue_word(MODE_KEY, ACT_SECONDARY, EV_UP);
      queue_word(MODE_KEY, ACT_DOUBLE, EV_UP);
      queue_word(MODE_KEY, ACT_PRIMARY, EV_UP);
      queue_word(MODE_KEY, ACT_CLICK, EV_DOWN);
      queue_word(MODE_KEY, ACT_CLICK, EV_REPEAT);
      queue_word(MODE_KEY, ACT_CLICK, EV_NONE);
      queue_word(MODE_KEY, ACT_DRAG_END, EV_DOWN);
      drain_unit();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: apply_settings(48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF,
                              '1, '1);
            1: apply_settings(48'h8000_0000_0000, 48'h8000_0000_0000, 48'h8000_0000_0000,
                              '0, '0);
            2: apply_settings('0, '0, '0, rand_limit(), rand_limit());
            default: apply_settings(rand_coef(), rand_coef(), rand_coef(),
                                    rand_limit(), rand_limit());
         endcase
         @(negedge clock);
         phase_words = 0;
         while (phase_words < PHASE_WORDS) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: begin
                  // press, move for a while, release everything
                  repeat ($urandom_range(1, 3)) queue_word(MODE_KEY,
                     4'($urandom_range(ACT_DOWN, ACT_UP)), EV_DOWN);
                  taps = $urandom_range(1, 14);
                  for (int i = 0; i < taps; i++) begin
                     case ($urandom_range(0, 9))
                        0: queue_word(MODE_KEY, 4'($urandom_range(ACT_CLICK, ACT_SECONDARY)),
                                      EV_UP);
                        1: queue_word(MODE_KEY, 4'($urandom_range(ACT_DOWN, ACT_UP)),
                                      2'($urandom_range(0, 3)));
                        default: queue_tick();
                     endcase
                  end
                  start = $urandom_range(0, 3);
                  for (int i = 0; i < 4; i++) begin
                     d = 4'((start + i) % 4);
                     if (gen_mask[d]) queue_word(MODE_KEY, d, EV_UP);
                  end
                  if ($urandom_range(0, 1) == 0) queue_tick();
               end
               6, 7: queue_word(MODE_KEY, 4'($urandom_range(ACT_CLICK, ACT_SECONDARY)),
                                ($urandom_range(0, 4) == 0) ? 2'($urandom_range(0, 3))
                                                           : EV_UP);
               default: queue_word(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                                   2'($urandom_range(0, 3)));
            endcase
         end
         if (phase == 3) hold_off_asks++;
         drain_unit();
      end

      if (mismatches == 0) begin
         $display("keypad_mouse_emulator_unit_tb OK");
      end else begin
         $display("keypad_mouse_emulator_unit_tb NOT OK");
      end
      $finish;
   end

endmodule

/* keypad_mouse_emulator_unit.f */
rtl/core/kme_pkg.sv
rtl/core/kme_speed_unit.sv
rtl/core/kme_axis_clamp.sv
rtl/core/keypad_mouse_emulator_unit.sv
sim/keypad_mouse_emulator_unit_tb.sv
